/* src/ttq_pkg.sv */
// Shared widths, reset values and register codes for the touch tap qualifier.
package ttq_pkg;

    // Field widths
    localparam int RAW_W   = 12;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 16;
    localparam int ORIENT_W = 3;
    localparam int COORD_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Packed stream widths (padded to whole bytes)
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;

    // Default screen geometry
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    // Register reset values
    localparam logic [RAW_W-1:0]    RAW_MIN_RST   = 12'd200;
    localparam logic [RAW_W-1:0]    RAW_MAX_RST   = 12'd3900;
    localparam logic [RAW_W-1:0]    PRESSURE_RST  = 12'd200;
    localparam logic [WIN_W-1:0]    DEBOUNCE_RST  = 16'd180;
    localparam logic [ORIENT_W-1:0] ORIENT_RST    = 3'd0;

    // Orientation bits
    localparam int ORIENT_SWAP = 0;
    localparam int ORIENT_INVX = 1;
    localparam int ORIENT_INVY = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAW_MIN_X    = 3'd0,
        CFG_RAW_MAX_X    = 3'd1,
        CFG_RAW_MIN_Y    = 3'd2,
        CFG_RAW_MAX_Y    = 3'd3,
        CFG_PRESSURE     = 3'd4,
        CFG_DEBOUNCE     = 3'd5,
        CFG_ORIENTATION  = 3'd6
    } cfg_index_t;

endpackage

/* src/touch_tap_qualifier_top.sv */
// Touch tap qualifier: press detection, debounce and serial calibration map.
//
//  Channel  Direction  Handshake                   Content
//  s_axis   in         s_axis_tvalid/tready        one touch sample
//  m_axis   out        m_axis_tvalid/tready        one qualified tap (screen x, y)
//  cfg      in         cfg_valid/cfg_ready         register index and write data
//
//  A sample that yields no tap leaves the block idle. A sample that yields a tap keeps
//  s_axis_tready low after its transaction: per axis a multiply state, 22 restoring
//  divide steps on the single shared subtract/compare unit and a finishing state, then
//  a load into the output register. The load waits while the output register still
//  holds an untaken tap; a next sample is accepted once the load is done. rst_n resets
//  all state asynchronously; cfg_ready is always high.
module touch_tap_qualifier_top #(
    parameter int SCREEN_WIDTH  = ttq_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ttq_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input samples
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: raw_x[11:0], raw_y[23:12], raw_pressure[35:24], now_ms[67:36], zeros
    input  logic [ttq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: pen_down[0]
    input  logic                             s_axis_tuser,
    // Output taps
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: tap_x[9:0], tap_y[19:10], zeros
    output logic [ttq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ttq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ttq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RAW_W   = ttq_pkg::RAW_W;
    localparam int COORD_W = ttq_pkg::COORD_W;
    localparam int TIME_W  = ttq_pkg::TIME_W;
    localparam int WIN_W   = ttq_pkg::WIN_W;
    localparam int ORIENT_W = ttq_pkg::ORIENT_W;
    localparam int PROD_W  = RAW_W + COORD_W;
    localparam int CNT_W   = $clog2(PROD_W);
    localparam int VAL_W   = PROD_W + 2;
    localparam logic [COORD_W-1:0] X_LAST = COORD_W'(SCREEN_WIDTH - 1);
    localparam logic [COORD_W-1:0] Y_LAST = COORD_W'(SCREEN_HEIGHT - 1);
    localparam logic [CNT_W-1:0]   CNT_TOP = CNT_W'(PROD_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN,
        S_LOAD
    } state_t;

    // Unpack the sample
    logic [RAW_W-1:0]  in_raw_x;
    logic [RAW_W-1:0]  in_raw_y;
    logic [RAW_W-1:0]  in_pressure;
    logic [TIME_W-1:0] in_now;

    assign in_raw_x    = s_axis_tdata[11:0];
    assign in_raw_y    = s_axis_tdata[23:12];
    assign in_pressure = s_axis_tdata[35:24];
    assign in_now      = s_axis_tdata[67:36];

    // Registers
    state_t               state_reg, state_next;
    logic [RAW_W-1:0]     min_x_reg, min_x_next;
    logic [RAW_W-1:0]     max_x_reg, max_x_next;
    logic [RAW_W-1:0]     min_y_reg, min_y_next;
    logic [RAW_W-1:0]     max_y_reg, max_y_next;
    logic [RAW_W-1:0]     thresh_reg, thresh_next;
    logic [WIN_W-1:0]     window_reg, window_next;
    logic [ORIENT_W-1:0]  orient_reg, orient_next;
    logic                 held_reg, held_next;
    logic                 seen_reg, seen_next;
    logic [TIME_W-1:0]    last_reg, last_next;
    logic [RAW_W-1:0]     ax_reg, ax_next;
    logic [RAW_W-1:0]     ay_reg, ay_next;
    logic                 axis_reg, axis_next;
    logic                 neg_reg, neg_next;
    logic                 span_ok_reg, span_ok_next;
    logic [RAW_W-1:0]     divisor_reg, divisor_next;
    logic [RAW_W-1:0]     rem_reg, rem_next;
    logic [PROD_W-1:0]    quot_reg, quot_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [COORD_W-1:0]   tx_reg, tx_next;
    logic [COORD_W-1:0]   ty_reg, ty_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]   out_x_reg, out_x_next;
    logic [COORD_W-1:0]   out_y_reg, out_y_next;

    // Per-axis operand selection
    logic [RAW_W-1:0]     sel_raw;
    logic [RAW_W-1:0]     sel_min;
    logic [RAW_W-1:0]     sel_max;
    logic [COORD_W-1:0]   sel_last;
    logic                 sel_invert;

    // Working values
    logic                 pressed;
    logic [TIME_W-1:0]    elapsed;
    logic                 in_window;
    logic signed [RAW_W:0] diff;
    logic [RAW_W-1:0]     diff_mag;
    logic [RAW_W:0]       partial;
    logic [RAW_W:0]       trial;
    logic                 fits;
    logic signed [VAL_W-1:0] val_q;
    logic signed [VAL_W-1:0] val_s;
    logic signed [VAL_W-1:0] val_i;
    logic signed [VAL_W-1:0] val_last;
    logic [COORD_W-1:0]   val_clamped;
    logic                 out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(ttq_pkg::OUT_DATA_W - 2*COORD_W){1'b0}}, out_y_reg, out_x_reg};

    // Select calibration for the axis in work
    always_comb
    begin
        if (axis_reg == 1'b0)
        begin
            sel_raw    = ax_reg;
            sel_min    = min_x_reg;
            sel_max    = max_x_reg;
            sel_last   = X_LAST;
            sel_invert = orient_reg[ttq_pkg::ORIENT_INVX];
        end
        else
        begin
            sel_raw    = ay_reg;
            sel_min    = min_y_reg;
            sel_max    = max_y_reg;
            sel_last   = Y_LAST;
            sel_invert = orient_reg[ttq_pkg::ORIENT_INVY];
        end
    end

    // Press and debounce qualification
    assign pressed   = s_axis_tuser && (in_pressure >= thresh_reg);
    assign elapsed   = in_now - last_reg;
    assign in_window = seen_reg && (elapsed < {{(TIME_W - WIN_W){1'b0}}, window_reg});

    // Offset from the calibration minimum, as sign and magnitude
    assign diff     = $signed({1'b0, sel_raw}) - $signed({1'b0, sel_min});
    assign diff_mag = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];

    // Shared restoring divide step
    assign partial = {rem_reg, quot_reg[PROD_W-1]};
    assign trial   = partial - {1'b0, divisor_reg};
    assign fits    = (partial >= {1'b0, divisor_reg});

    // Sign, invert and clamp of the quotient
    assign val_q    = $signed({2'b00, quot_reg});
    assign val_last = $signed({{(VAL_W - COORD_W){1'b0}}, sel_last});
    always_comb
    begin
        if (!span_ok_reg)
            val_s = '0;
        else if (neg_reg)
            val_s = -val_q;
        else
            val_s = val_q;
        val_i = sel_invert ? (val_last - val_s) : val_s;
        if (val_i < 0)
            val_clamped = '0;
        else if (val_i > val_last)
            val_clamped = sel_last;
        else
            val_clamped = val_i[COORD_W-1:0];
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    // Sequencer and register next values
    always_comb
    begin
        state_next     = state_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        thresh_next    = thresh_reg;
        window_next    = window_reg;
        orient_next    = orient_reg;
        held_next      = held_reg;
        seen_next      = seen_reg;
        last_next      = last_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        axis_next      = axis_reg;
        neg_next       = neg_reg;
        span_ok_next   = span_ok_reg;
        divisor_next   = divisor_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;

        // Drop the output transaction once taken
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        // Register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                ttq_pkg::CFG_RAW_MIN_X:   min_x_next  = cfg_data[RAW_W-1:0];
                ttq_pkg::CFG_RAW_MAX_X:   max_x_next  = cfg_data[RAW_W-1:0];
                ttq_pkg::CFG_RAW_MIN_Y:   min_y_next  = cfg_data[RAW_W-1:0];
                ttq_pkg::CFG_RAW_MAX_Y:   max_y_next  = cfg_data[RAW_W-1:0];
                ttq_pkg::CFG_PRESSURE:    thresh_next = cfg_data[RAW_W-1:0];
                ttq_pkg::CFG_DEBOUNCE:    window_next = cfg_data[WIN_W-1:0];
                ttq_pkg::CFG_ORIENTATION: orient_next = cfg_data[ORIENT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (!pressed)
                        held_next = 1'b0;
                    else if (!held_reg)
                    begin
                        held_next = 1'b1;
                        if (!in_window)
                        begin
                            seen_next  = 1'b1;
                            last_next  = in_now;
                            axis_next  = 1'b0;
                            state_next = S_MUL;
                            if (orient_reg[ttq_pkg::ORIENT_SWAP])
                            begin
                                ax_next = in_raw_y;
                                ay_next = in_raw_x;
                            end
                            else
                            begin
                                ax_next = in_raw_x;
                                ay_next = in_raw_y;
                            end
                        end
                    end
                end
            end

            // Scale the offset and set up the divide
            S_MUL:
            begin
                neg_next     = diff[RAW_W];
                span_ok_next = (sel_max > sel_min);
                divisor_next = sel_max - sel_min;
                quot_next    = PROD_W'(diff_mag) * PROD_W'(sel_last);
                rem_next     = '0;
                cnt_next     = CNT_TOP;
                state_next   = S_DIV;
            end

            // One quotient bit per cycle
            S_DIV:
            begin
                rem_next  = fits ? trial[RAW_W-1:0] : partial[RAW_W-1:0];
                quot_next = {quot_reg[PROD_W-2:0], fits};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_FIN;
            end

            // Finish the axis, then advance to the next axis or, after y, to the load
            S_FIN:
            begin
                if (axis_reg == 1'b0)
                begin
                    tx_next    = val_clamped;
                    axis_next  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    ty_next    = val_clamped;
                    state_next = S_LOAD;
                end
            end

            // Hold the tap until the output register is free
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = tx_reg;
                    out_y_next     = ty_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_x_reg     <= ttq_pkg::RAW_MIN_RST;
            max_x_reg     <= ttq_pkg::RAW_MAX_RST;
            min_y_reg     <= ttq_pkg::RAW_MIN_RST;
            max_y_reg     <= ttq_pkg::RAW_MAX_RST;
            thresh_reg    <= ttq_pkg::PRESSURE_RST;
            window_reg    <= ttq_pkg::DEBOUNCE_RST;
            orient_reg    <= ttq_pkg::ORIENT_RST;
            held_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            last_reg      <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            axis_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            span_ok_reg   <= 1'b0;
            divisor_reg   <= '0;
            rem_reg       <= '0;
            quot_reg      <= '0;
            cnt_reg       <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            thresh_reg    <= thresh_next;
            window_reg    <= window_next;
            orient_reg    <= orient_next;
            held_reg      <= held_next;
            seen_reg      <= seen_next;
            last_reg      <= last_next;
            ax_reg        <= ax_next;
            ay_reg        <= ay_next;
            axis_reg      <= axis_next;
            neg_reg       <= neg_next;
            span_ok_reg   <= span_ok_next;
            divisor_reg   <= divisor_next;
            rem_reg       <= rem_next;
            quot_reg      <= quot_next;
            cnt_reg       <= cnt_next;
            tx_reg        <= tx_next;
            ty_reg        <= ty_next;
            out_valid_reg <= out_valid_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
        end
    end

endmodule

/* test/tb_touch_tap_qualifier_top.sv */
// Self-checking testbench for the touch tap qualifier: directed table, then random press sequences.
`timescale 1ns / 1ps

module tb_touch_tap_qualifier_top;

    localparam int RAW_W          = ttq_pkg::RAW_W;
    localparam int TIME_W         = ttq_pkg::TIME_W;
    localparam int WIN_W          = ttq_pkg::WIN_W;
    localparam int ORIENT_W       = ttq_pkg::ORIENT_W;
    localparam int COORD_W        = ttq_pkg::COORD_W;
    localparam int CFG_DATA_W     = ttq_pkg::CFG_DATA_W;
    localparam int IN_DATA_W      = ttq_pkg::IN_DATA_W;
    localparam int OUT_DATA_W     = ttq_pkg::OUT_DATA_W;
    localparam int SCR_W          = ttq_pkg::SCREEN_WIDTH_DEF;
    localparam int SCR_H          = ttq_pkg::SCREEN_HEIGHT_DEF;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int BLOCK_COUNT    = 12;
    localparam int BLOCK_ITEMS    = 104;
    localparam int DIR_ROWS       = 20;

    typedef enum logic [1:0] {
        ROW_CHECKED,
        ROW_TAP,
        ROW_SILENT
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               pen;
        logic [RAW_W-1:0]   rx;
        logic [RAW_W-1:0]   ry;
        logic [RAW_W-1:0]   rz;
        logic [TIME_W-1:0]  now;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } sample_row_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } tap_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    ttq_pkg::cfg_index_t     cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // Shadow registers and state of the tap predictor
    logic [RAW_W-1:0]    min_x_q;
    logic [RAW_W-1:0]    max_x_q;
    logic [RAW_W-1:0]    min_y_q;
    logic [RAW_W-1:0]    max_y_q;
    logic [RAW_W-1:0]    thr_q;
    logic [WIN_W-1:0]    win_q;
    logic [ORIENT_W-1:0] orient_q;
    logic                held_q;
    logic [TIME_W-1:0]   last_tap_ms;
    logic                tap_since_reset;

    tap_t        pending_taps[$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_off_req;
    logic [TIME_W-1:0] sample_ms;
    logic        pen_pressing;

    // Directed samples under reset settings (threshold 200, window 180)
    sample_row_t dir_rows [DIR_ROWS] = '{
        // first tap after reset, inside the window from time zero: no debounce yet
        '{ROW_TAP,     1'b1, 12'd200,  12'd200,  12'd4095, 32'd50,         10'd0,   10'd0},
        '{ROW_SILENT,  1'b0, 12'd0,    12'd0,    12'd0,    32'd1010,       10'd0,   10'd0},
        // pressure exactly at threshold, raw exactly at calibration maximum
        '{ROW_TAP,     1'b1, 12'd3900, 12'd3900, 12'd200,  32'd1300,       10'd319, 10'd239},
        // held press
        '{ROW_SILENT,  1'b1, 12'd100,  12'd100,  12'd4095, 32'd1310,       10'd0,   10'd0},
        // pen up with full pressure
        '{ROW_SILENT,  1'b0, 12'd4095, 12'd4095, 12'd4095, 32'd1320,       10'd0,   10'd0},
        // one millisecond short of the window
        '{ROW_SILENT,  1'b1, 12'd2000, 12'd2000, 12'd4095, 32'd1479,       10'd0,   10'd0},
        // pressure one below threshold releases
        '{ROW_SILENT,  1'b1, 12'd2000, 12'd2000, 12'd199,  32'd1479,       10'd0,   10'd0},
        // window exactly elapsed, raw at top clamps high
        '{ROW_TAP,     1'b1, 12'd4095, 12'd4095, 12'd4095, 32'd1480,       10'd319, 10'd239},
        '{ROW_SILENT,  1'b0, 12'd0,    12'd0,    12'd0,    32'd1500,       10'd0,   10'd0},
        // raw below calibration minimum clamps low
        '{ROW_TAP,     1'b1, 12'd0,    12'd0,    12'd3000, 32'd2000,       10'd0,   10'd0},
        '{ROW_SILENT,  1'b0, 12'd0,    12'd0,    12'd0,    32'd2010,       10'd0,   10'd0},
        '{ROW_CHECKED, 1'b1, 12'd2050, 12'd1234, 12'd1024, 32'hFFFF_FFF0,  10'd0,   10'd0},
        '{ROW_SILENT,  1'b0, 12'd0,    12'd0,    12'd0,    32'hFFFF_FFFF,  10'd0,   10'd0},
        // time wrapped: elapsed is small, so debounced
        '{ROW_SILENT,  1'b1, 12'd1,    12'd1,    12'd4095, 32'h0000_0010,  10'd0,   10'd0},
        '{ROW_SILENT,  1'b0, 12'd0,    12'd0,    12'd0,    32'h0000_0020,  10'd0,   10'd0},
        '{ROW_CHECKED, 1'b1, 12'hAAA,  12'h555,  12'h800,  32'h0000_0100,  10'd0,   10'd0},
        '{ROW_SILENT,  1'b0, 12'h555,  12'hAAA,  12'd0,    32'h0000_0120,  10'd0,   10'd0},
        // zero pressure with pen down is no press
        '{ROW_SILENT,  1'b1, 12'hFFF,  12'h000,  12'd0,    32'h0000_0200,  10'd0,   10'd0},
        '{ROW_CHECKED, 1'b1, 12'h7FF,  12'h800,  12'd200,  32'h5555_5555,  10'd0,   10'd0},
        '{ROW_SILENT,  1'b0, 12'h000,  12'hFFF,  12'hFFF,  32'hAAAA_AAAA,  10'd0,   10'd0}
    };

    touch_tap_qualifier_top #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #5_000_000;
        $display("touch_tap_qualifier_top test failed");
        $finish;
    end

    // Calibrate one axis, truncating toward zero; a degenerate span maps to zero
    function automatic int map_axis(input int raw, input int lo, input int hi, input int size);
        if (hi <= lo)
            return 0;
        return ((raw - lo) * (size - 1)) / (hi - lo);
    endfunction

    // Invert if asked, then clamp to the screen
    function automatic int finish_axis(input int v, input logic invert, input int size);
        int r;
        r = invert ? (size - 1 - v) : v;
        if (r < 0)
            r = 0;
        if (r > size - 1)
            r = size - 1;
        return r;
    endfunction

    // Advance the press and debounce state; return 1 with the tap when one is due
    function automatic logic predict_tap(input logic pen, input logic [RAW_W-1:0] rx,
                                         input logic [RAW_W-1:0] ry,
                                         input logic [RAW_W-1:0] rz,
                                         input logic [TIME_W-1:0] now, output tap_t tap);
        logic [TIME_W-1:0] elapsed;
        logic [RAW_W-1:0]  ax;
        logic [RAW_W-1:0]  ay;
        int                mx;
        int                my;
        tap = '0;
        if (!(pen && rz >= thr_q))
        begin
            held_q = 1'b0;
            return 1'b0;
        end
        if (held_q)
            return 1'b0;
        held_q = 1'b1;
        elapsed = now - last_tap_ms;
        if (tap_since_reset && elapsed < {16'd0, win_q})
            return 1'b0;
        tap_since_reset = 1'b1;
        last_tap_ms = now;
        ax = orient_q[ttq_pkg::ORIENT_SWAP] ? ry : rx;
        ay = orient_q[ttq_pkg::ORIENT_SWAP] ? rx : ry;
        mx = map_axis(int'(ax), int'(min_x_q), int'(max_x_q), SCR_W);
        my = map_axis(int'(ay), int'(min_y_q), int'(max_y_q), SCR_H);
        mx = finish_axis(mx, orient_q[ttq_pkg::ORIENT_INVX], SCR_W);
        my = finish_axis(my, orient_q[ttq_pkg::ORIENT_INVY], SCR_H);
        tap.x = mx[COORD_W-1:0];
        tap.y = my[COORD_W-1:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Offer one sample and hold it until the transaction completes
    task automatic offer_sample(input logic pen, input logic [RAW_W-1:0] rx,
                                input logic [RAW_W-1:0] ry, input logic [RAW_W-1:0] rz,
                                input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, now, rz, ry, rx};
        s_axis_tuser  <= pen;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Write one register and mirror it into the shadow copy
    task automatic write_register(input ttq_pkg::cfg_index_t idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ttq_pkg::CFG_RAW_MIN_X:   min_x_q  = value[RAW_W-1:0];
            ttq_pkg::CFG_RAW_MAX_X:   max_x_q  = value[RAW_W-1:0];
            ttq_pkg::CFG_RAW_MIN_Y:   min_y_q  = value[RAW_W-1:0];
            ttq_pkg::CFG_RAW_MAX_Y:   max_y_q  = value[RAW_W-1:0];
            ttq_pkg::CFG_PRESSURE:    thr_q    = value[RAW_W-1:0];
            ttq_pkg::CFG_DEBOUNCE:    win_q    = value[WIN_W-1:0];
            ttq_pkg::CFG_ORIENTATION: orient_q = value[ORIENT_W-1:0];
            default: ;
        endcase
    endtask

    // Choose a setting for this block, extremes on fixed blocks, and write every register
    task automatic program_setting(input int blk);
        logic [RAW_W-1:0]    mnx;
        logic [RAW_W-1:0]    mxx;
        logic [RAW_W-1:0]    mny;
        logic [RAW_W-1:0]    mxy;
        logic [RAW_W-1:0]    thr;
        logic [WIN_W-1:0]    win;
        logic [ORIENT_W-1:0] ori;
        mnx = RAW_W'($urandom_range(1500));
        mxx = RAW_W'($urandom_range(4095, 2500));
        mny = RAW_W'($urandom_range(1500));
        mxy = RAW_W'($urandom_range(4095, 2500));
        thr = RAW_W'($urandom_range(1000));
        win = WIN_W'($urandom_range(1000));
        ori = ORIENT_W'($urandom_range(7));
        // now and then an arbitrary calibration, possibly with max below min
        if ($urandom_range(4) == 0)
        begin
            mnx = RAW_W'($urandom_range(4095));
            mxx = RAW_W'($urandom_range(4095));
            mny = RAW_W'($urandom_range(4095));
            mxy = RAW_W'($urandom_range(4095));
        end
        case (blk)
            1:
            begin
                mnx = 12'd0;
                mxx = 12'hFFF;
                mny = 12'd0;
                mxy = 12'hFFF;
                thr = 12'd0;
                win = 16'd0;
                ori = 3'd7;
            end
            2:
            begin
                mnx = 12'hFFF;
                mxx = 12'd0;
                mny = 12'hFFF;
                mxy = 12'd0;
                thr = 12'hFFF;
                win = 16'hFFFF;
                ori = 3'd1;
            end
            3:
            begin
                mxx = mnx;
                mxy = mny;
            end
            6:       win = WIN_W'($urandom_range(65535));
            9:
            begin
                ori = 3'd0;
                thr = RAW_W'($urandom_range(4095));
            end
            default: ;
        endcase
        write_register(ttq_pkg::CFG_RAW_MIN_X,   {4'b0, mnx});
        write_register(ttq_pkg::CFG_RAW_MAX_X,   {4'b0, mxx});
        write_register(ttq_pkg::CFG_RAW_MIN_Y,   {4'b0, mny});
        write_register(ttq_pkg::CFG_RAW_MAX_Y,   {4'b0, mxy});
        write_register(ttq_pkg::CFG_PRESSURE,    {4'b0, thr});
        write_register(ttq_pkg::CFG_DEBOUNCE,    win);
        write_register(ttq_pkg::CFG_ORIENTATION, {13'b0, ori});
        cfg_valid <= 1'b0;
    endtask

    // Wait for every expected tap, then let the block finish any silent sample
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (pending_taps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly press/release sequences with time stepped against the window, some noise
    task automatic run_random_block(input int count);
        logic             pen;
        logic [RAW_W-1:0] rx;
        logic [RAW_W-1:0] ry;
        logic [RAW_W-1:0] rz;
        int               step_span;
        tap_t             tap;
        for (int i = 0; i < count; i++)
        begin
            rx = RAW_W'($urandom_range(4095));
            ry = RAW_W'($urandom_range(4095));
            if ($urandom_range(99) < 15)
            begin
                pen       = 1'($urandom_range(1));
                rz        = RAW_W'($urandom_range(4095));
                sample_ms = $urandom();
            end
            else
            begin
                step_span = int'(win_q);
                step_span = step_span + step_span / 2 + 20;
                sample_ms = sample_ms + $urandom_range(step_span);
                if ($urandom_range(99) < 60)
                    pen_pressing = ~pen_pressing;
                if (pen_pressing)
                begin
                    pen = 1'b1;
                    rz  = RAW_W'($urandom_range(4095, int'(thr_q)));
                end
                else if (thr_q != 0 && $urandom_range(1) == 1)
                begin
                    pen = 1'b1;
                    rz  = RAW_W'($urandom_range(int'(thr_q) - 1, 0));
                end
                else
                begin
                    pen = 1'b0;
                    rz  = RAW_W'($urandom_range(4095));
                end
            end
            offer_sample(pen, rx, ry, rz, sample_ms);
            if (predict_tap(pen, rx, ry, rz, sample_ms, tap))
                pending_taps.push_back(tap);
        end
    endtask

    // Drive the receiver: random back-pressure, with one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req  <= 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each tap transaction with the oldest expectation
    always @(posedge clk)
    begin : tap_check
        tap_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_taps.size() == 0)
                report_mismatch("tap with none expected, x", int'(m_axis_tdata[9:0]), -1);
            else
            begin
                want = pending_taps.pop_front();
                if (m_axis_tdata[9:0] !== want.x)
                    report_mismatch("tap_x", int'(m_axis_tdata[9:0]), int'(want.x));
                if (m_axis_tdata[19:10] !== want.y)
                    report_mismatch("tap_y", int'(m_axis_tdata[19:10]), int'(want.y));
            end
        end
    end

    // Main sequence: reset, directed table, then random blocks under changing settings
    initial
    begin : stimulus
        sample_row_t row;
        tap_t        tap;
        logic        due;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = ttq_pkg::CFG_RAW_MIN_X;
        cfg_data        = '0;
        hold_off_req    = 1'b0;
        send_idle_pct   = 30;
        recv_idle_pct   = 67;
        mismatch_count  = 0;
        min_x_q         = ttq_pkg::RAW_MIN_RST;
        max_x_q         = ttq_pkg::RAW_MAX_RST;
        min_y_q         = ttq_pkg::RAW_MIN_RST;
        max_y_q         = ttq_pkg::RAW_MAX_RST;
        thr_q           = ttq_pkg::PRESSURE_RST;
        win_q           = ttq_pkg::DEBOUNCE_RST;
        orient_q        = ttq_pkg::ORIENT_RST;
        held_q          = 1'b0;
        last_tap_ms     = '0;
        tap_since_reset = 1'b0;
        sample_ms       = 32'h6000_0000;
        pen_pressing    = 1'b0;
        rst_n           = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_rows[i];
            offer_sample(row.pen, row.rx, row.ry, row.rz, row.now);
            due = predict_tap(row.pen, row.rx, row.ry, row.rz, row.now, tap);
            case (row.kind)
                ROW_CHECKED:
                    if (due)
                        pending_taps.push_back(tap);
                ROW_TAP:
                begin
                    tap.x = row.ex;
                    tap.y = row.ey;
                    pending_taps.push_back(tap);
                end
                default: ;
            endcase
        end

        // Random blocks; swap the idling pattern part way, then run flat out
        for (int blk = 0; blk < BLOCK_COUNT; blk++)
        begin
            drain_and_settle();
            if (blk == 4)
            begin
                send_idle_pct = 67;
                recv_idle_pct <= 30;
            end
            else if (blk == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            program_setting(blk);
            if (blk == 1)
                hold_off_req <= 1'b1;
            run_random_block(BLOCK_ITEMS);
        end

        drain_and_settle();
        if (mismatch_count == 0)
            $display("touch_tap_qualifier_top test passed");
        else
            $display("touch_tap_qualifier_top test failed");
        $finish;
    end

endmodule
